// ===== sv/rcde_pkg.sv =====
// rcde_pkg: shared constants and the digit-to-ascii mapping for the radix
// conversion digit emitter. No dependencies; used by every other file but rcde_digit_store.

package rcde_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index of the radix register in the word-addressed map
    localparam logic [APB_ADDR_W-3:0] REG_RADIX = '0;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CH_DIGIT_BASE  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_LETTER_BASE = 7'd55;
    localparam logic [CHAR_W-1:0] CH_POINT       = 7'd46;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE    = 6'd9;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d <= DIGIT_NINE) begin
            return d_ext + CH_DIGIT_BASE;
        end else begin
            return d_ext + CH_LETTER_BASE;
        end
    endfunction

endpackage

// ===== sv/rcde_cfg_regs.sv =====
// rcde_cfg_regs: apb-style register slave holding the radix register.
// Depends on rcde_pkg for the address map and radix limits.

module rcde_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcde_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rcde_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rcde_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [rcde_pkg::DIGIT_W-1:0]      radix
);

    logic [rcde_pkg::DIGIT_W-1:0] radix_reg;
    logic [rcde_pkg::DIGIT_W-1:0] radix_next;
    logic [rcde_pkg::DIGIT_W-1:0] wr_value;
    logic                         hit_radix;
    logic                         wr_strobe;

    assign pready    = 1'b1;
    assign hit_radix = (paddr[rcde_pkg::APB_ADDR_W-1:2] == rcde_pkg::REG_RADIX);
    assign wr_strobe = psel && penable && pwrite && pready;
    assign wr_value  = pwdata[rcde_pkg::DIGIT_W-1:0];

    // out-of-range bases are dropped silently
    always_comb begin
        radix_next = radix_reg;
        if (wr_strobe && hit_radix && (wr_value >= rcde_pkg::RADIX_MIN)
                && (wr_value <= rcde_pkg::RADIX_MAX)) begin
            radix_next = wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rcde_pkg::RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit_radix) begin
            prdata[rcde_pkg::DIGIT_W-1:0] = radix_reg;
        end
    end

    assign radix = radix_reg;

endmodule

// ===== sv/rcde_digit_store.sv =====
// rcde_digit_store: integer digit memory, one write and one registered read
// port. Depends on nothing; widths come from its parameters.

module rcde_digit_store #(
    parameter int DEPTH  = 31,
    parameter int DATA_W = 6
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] digit_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rcde_seq.sv =====
// rcde_seq: sequencer around one shared compare-subtract step (bit-serial
// division by the radix), the fraction multiply-by-base and the output register.
// Depends on rcde_pkg and drives the ports of rcde_digit_store.

module rcde_seq #(
    parameter int WHOLE_BITS      = 31,
    parameter int FRACTION_DIGITS = 8,
    parameter int FRACTION_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [rcde_pkg::DIGIT_W-1:0]      radix,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [WHOLE_BITS-1:0]             s_whole_value,
    input  logic [FRACTION_BITS-1:0]          s_fraction_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rcde_pkg::CHAR_W-1:0]       m_character,
    output logic                              m_final_char,
    output logic                              st_wr_en,
    output logic [$clog2(WHOLE_BITS)-1:0]     st_wr_addr,
    output logic [rcde_pkg::DIGIT_W-1:0]      st_wr_data,
    output logic [$clog2(WHOLE_BITS)-1:0]     st_rd_addr,
    input  logic [rcde_pkg::DIGIT_W-1:0]      st_rd_data
);

    localparam int DW   = rcde_pkg::DIGIT_W;
    localparam int AW   = $clog2(WHOLE_BITS);
    localparam int CW   = $clog2(WHOLE_BITS + 1);
    localparam int FW   = $clog2(FRACTION_DIGITS + 1);
    localparam int PW   = FRACTION_BITS + DW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_INT   = 3'd3;
    localparam logic [2:0] ST_POINT = 3'd4;
    localparam logic [2:0] ST_FRAC  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [WHOLE_BITS-1:0]      v_reg, v_next;
    logic [DW-1:0]              rem_reg, rem_next;
    logic [AW-1:0]              bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [FRACTION_BITS-1:0]   frac_reg, frac_next;
    logic                       frac_nz_reg, frac_nz_next;
    logic [FW-1:0]              fcnt_reg, fcnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [rcde_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       final_reg, final_next;

    logic [DW:0]                div_t;
    logic [DW:0]                radix_ext;
    logic [DW:0]                div_diff;
    logic                       div_ge;
    logic [DW-1:0]              rem_step;
    logic [WHOLE_BITS-1:0]      v_step;
    logic                       div_last;
    logic [CW-1:0]              cnt_m1;
    logic [PW-1:0]              prod;
    logic [DW-1:0]              frac_digit;
    logic                       out_free;
    logic                       out_load;

    // shared step: shift in the next dividend bit, subtract the base if it fits
    assign div_t     = {rem_reg, v_reg[WHOLE_BITS-1]};
    assign radix_ext = {1'b0, radix};
    assign div_diff  = div_t - radix_ext;
    assign div_ge    = (div_t >= radix_ext);
    assign rem_step  = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
    assign v_step    = {v_reg[WHOLE_BITS-2:0], div_ge};
    assign div_last  = (bit_cnt_reg == AW'(WHOLE_BITS - 1));

    // fraction times base, integer part on top is the digit
    assign prod       = {{DW{1'b0}}, frac_reg} * {{FRACTION_BITS{1'b0}}, radix};
    assign frac_digit = prod[PW-1:FRACTION_BITS];

    assign cnt_m1   = cnt_reg - CW'(1);
    assign out_free = !out_valid_reg || m_ready;

    assign st_wr_en   = (state_reg == ST_DIV) && div_last;
    assign st_wr_addr = cnt_reg[AW-1:0];
    assign st_wr_data = rem_step;
    assign st_rd_addr = cnt_m1[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        v_next       = v_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        frac_next    = frac_reg;
        frac_nz_next = frac_nz_reg;
        fcnt_next    = fcnt_reg;
        char_next    = char_reg;
        final_next   = final_reg;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    v_next       = s_whole_value;
                    frac_next    = s_fraction_value;
                    frac_nz_next = (s_fraction_value != '0);
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                v_next       = v_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + AW'(1);
                if (div_last) begin
                    cnt_next     = cnt_reg + CW'(1);
                    bit_cnt_next = '0;
                    rem_next     = '0;
                    if ((v_step == '0) || (cnt_reg == CW'(WHOLE_BITS - 1))) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_INT;
            end
            ST_INT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    char_next  = rcde_pkg::ascii_of(st_rd_data);
                    final_next = (cnt_reg == CW'(1)) && !frac_nz_reg;
                    cnt_next   = cnt_m1;
                    if (cnt_reg == CW'(1)) begin
                        state_next = frac_nz_reg ? ST_POINT : ST_IDLE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    char_next  = rcde_pkg::CH_POINT;
                    final_next = 1'b0;
                    fcnt_next  = '0;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    char_next  = rcde_pkg::ascii_of(frac_digit);
                    frac_next  = prod[FRACTION_BITS-1:0];
                    final_next = (fcnt_reg == FW'(FRACTION_DIGITS - 1));
                    fcnt_next  = fcnt_reg + FW'(1);
                    if (fcnt_reg == FW'(FRACTION_DIGITS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            bit_cnt_reg   <= '0;
            fcnt_reg      <= '0;
            frac_nz_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            fcnt_reg      <= fcnt_next;
            frac_nz_reg   <= frac_nz_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        frac_reg <= frac_next;
        char_reg <= char_next;
        final_reg <= final_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_character  = char_reg;
    assign m_final_char = final_reg;

    // remainder stays below the base throughout a division pass
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < radix))
        else $error("division remainder reached the base");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= CW'(WHOLE_BITS)))
        else $error("digit count beyond store depth");

    a_request_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV) && (cnt_reg == '0))
        else $error("accepted request did not start division");

    a_final_ends_number: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && final_next) |=> (state_reg == ST_IDLE))
        else $error("final character loaded but sequencer still busy");

    a_frac_only_if_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_POINT) || (state_reg == ST_FRAC)) |-> frac_nz_reg)
        else $error("fraction digits for a zero fraction");

endmodule

// ===== sv/radix_conversion_digit_emitter.sv =====
// radix_conversion_digit_emitter: top level, ties config registers, sequencer
// and digit store together. Depends on rcde_pkg, rcde_cfg_regs, rcde_seq, rcde_digit_store.
//
//   A request on the s_ channel carries an unsigned integer part
//   (s_whole_value) and an unsigned fixed-point fraction (s_fraction_value).
//   The m_ channel returns one ascii character per transfer: the integer
//   digits most significant first (a single '0' for a zero integer part),
//   then, for a nonzero fraction, '.' and FRACTION_DIGITS fraction digits;
//   m_final_char marks the last one. The base (2 to 36, reset 10) sits in the
//   radix register at apb address 0; out-of-range writes are dropped. Write it
//   only while the block is idle.
//   s_ready is high only in idle. Each integer digit costs a full pass of the
//   shared compare-subtract step over all WHOLE_BITS dividend bits, each
//   integer character a digit store read (ST_FETCH, then ST_INT), and each
//   fraction digit one multiply by the base. A stalled m_ready holds the output
//   register and the sequencer waits on it; the next request is taken once the
//   last character is in the output register. Reset (aresetn low, synchronous)
//   empties the output register, idles the sequencer and sets the radix to 10.

module radix_conversion_digit_emitter #(
    parameter int WHOLE_BITS      = 31,
    parameter int FRACTION_DIGITS = 8,
    parameter int FRACTION_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcde_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rcde_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rcde_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [WHOLE_BITS-1:0]             s_whole_value,
    input  logic [FRACTION_BITS-1:0]          s_fraction_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rcde_pkg::CHAR_W-1:0]       m_character,
    output logic                              m_final_char
);

    localparam int AW = $clog2(WHOLE_BITS);

    logic [rcde_pkg::DIGIT_W-1:0] radix;
    logic                         st_wr_en;
    logic [AW-1:0]                st_wr_addr;
    logic [rcde_pkg::DIGIT_W-1:0] st_wr_data;
    logic [AW-1:0]                st_rd_addr;
    logic [rcde_pkg::DIGIT_W-1:0] st_rd_data;

    rcde_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    rcde_digit_store #(
        .DEPTH  (WHOLE_BITS),
        .DATA_W (rcde_pkg::DIGIT_W)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    rcde_seq #(
        .WHOLE_BITS      (WHOLE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .radix            (radix),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_whole_value    (s_whole_value),
        .s_fraction_value (s_fraction_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_character      (m_character),
        .m_final_char     (m_final_char),
        .st_wr_en         (st_wr_en),
        .st_wr_addr       (st_wr_addr),
        .st_wr_data       (st_wr_data),
        .st_rd_addr       (st_rd_addr),
        .st_rd_data       (st_rd_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for radix_conversion_digit_emitter, predicting each
// ascii character of every converted number and comparing on the m_ channel.
// Depends on rcde_pkg and the emitter rtl; stimulus and radix settings are partly directed, partly random.

module testbench;

    localparam int WHOLE_W         = 31;
    localparam int FRAC_W          = 32;
    localparam int FRACTION_DIGITS = 8;
    localparam int CHAR_W          = rcde_pkg::CHAR_W;
    localparam int DIGIT_W         = rcde_pkg::DIGIT_W;
    localparam int ADDR_W          = rcde_pkg::APB_ADDR_W;
    localparam int DATA_W          = rcde_pkg::APB_DATA_W;

    localparam logic [ADDR_W-1:0] RADIX_ADDR = {rcde_pkg::REG_RADIX, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam bit APB_WRITE = 1'b1;
    localparam bit APB_READ  = 1'b0;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;

    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 10000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } out_char_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [WHOLE_W-1:0] s_whole_value;
    logic [FRAC_W-1:0] s_fraction_value;
    logic m_valid, m_ready;
    logic [CHAR_W-1:0] m_character;
    logic m_final_char;

    out_char_t expected_chars[$];
    logic [DIGIT_W-1:0] cur_radix = rcde_pkg::RADIX_RESET;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;

    radix_conversion_digit_emitter #(
        .WHOLE_BITS     (WHOLE_W),
        .FRACTION_DIGITS(FRACTION_DIGITS),
        .FRACTION_BITS  (FRAC_W)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_whole_value   (s_whole_value),
        .s_fraction_value(s_fraction_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_character     (m_character),
        .m_final_char    (m_final_char)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < 10) begin
            return ASCII_ZERO + {1'b0, d};
        end
        return ASCII_A - 7'd10 + {1'b0, d};
    endfunction

    // integer digits least significant first, emitted in reverse; then point and
    // fraction digits from exact multiply-by-radix with truncation
    task automatic predict_number(input logic [WHOLE_W-1:0] whole, input logic [FRAC_W-1:0] frac);
        logic [DIGIT_W-1:0] digits [WHOLE_W];
        logic [WHOLE_W-1:0] left;
        logic [FRAC_W-1:0] frac_left;
        logic [FRAC_W+DIGIT_W-1:0] product;
        int ndig;
        left = whole;
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_W'(left % cur_radix);
            left = left / cur_radix;
            ndig++;
        end while (left != 0 && ndig < WHOLE_W);
        for (int n = ndig - 1; n >= 0; n--) begin
            expected_chars.push_back('{code: digit_char(digits[n]), last: (n == 0 && frac == 0)});
        end
        if (frac != 0) begin
            expected_chars.push_back('{code: ASCII_POINT, last: 1'b0});
            frac_left = frac;
            for (int i = 0; i < FRACTION_DIGITS; i++) begin
                product = frac_left * cur_radix;
                expected_chars.push_back('{code: digit_char(product[FRAC_W+DIGIT_W-1:FRAC_W]),
                                           last: (i == FRACTION_DIGITS - 1)});
                frac_left = product[FRAC_W-1:0];
            end
        end
    endtask

    task automatic apb_transfer(input bit is_write, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (is_write) begin
            // only the low six bits count, and only in-range values stick
            if (addr == RADIX_ADDR && data[DIGIT_W-1:0] >= rcde_pkg::RADIX_MIN
                    && data[DIGIT_W-1:0] <= rcde_pkg::RADIX_MAX) begin
                cur_radix = data[DIGIT_W-1:0];
            end
        end else if (prdata !== {{(DATA_W-DIGIT_W){1'b0}}, cur_radix}) begin
            flag_mismatch("radix readback", cur_radix, prdata);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_number(input logic [WHOLE_W-1:0] whole, input logic [FRAC_W-1:0] frac,
                               input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_whole_value <= whole;
        s_fraction_value <= frac;
        do @(posedge aclk); while (!s_ready);
        predict_number(whole, frac);
    endtask

    // drop the request line and wait until every predicted character is back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly short integer parts, since each digit costs a full division pass
    function automatic logic [WHOLE_W-1:0] random_whole();
        int r, w;
        logic [31:0] mask;
        r = $urandom_range(0, 99);
        if (r < 70) w = $urandom_range(0, 12);
        else if (r < 90) w = $urandom_range(13, 24);
        else w = $urandom_range(25, 31);
        mask = (w == 0) ? 32'd0 : ((32'd1 << w) - 32'd1);
        return WHOLE_W'($urandom & mask);
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 35) return $urandom_range(1, 255);
        if (r < 45) return $urandom & 32'hFF00_0000;
        return $urandom;
    endfunction

    task automatic test_reset_state();
        apb_transfer(APB_READ, RADIX_ADDR, '0);
        send_number('0, '0, 0);
        send_number(31'h7FFF_FFFF, '0, 0);
        send_number('0, 32'hFFFF_FFFF, 1);
        send_number('0, 32'h0000_0001, 0);
        send_number(31'd1234, 32'h8000_0000, 2);
        send_number(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    endtask

    task automatic test_base_two();
        settle();
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd2);
        apb_transfer(APB_READ, RADIX_ADDR, '0);
        send_number('0, '0, 0);
        send_number(31'h7FFF_FFFF, '0, 0);
        send_number(31'h4000_0000, 32'hAAAA_AAAA, 3);
        send_number(31'd5, 32'h0000_0001, 0);
    endtask

    task automatic test_base_thirty_six();
        settle();
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd36);
        apb_transfer(APB_READ, RADIX_ADDR, '0);
        send_number(31'd35, '0, 0);
        send_number(31'd36, '0, 0);
        send_number(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        send_number('0, 32'h7FFF_FFFF, 0);
    endtask

    // out-of-range values and the unmapped address must leave the radix alone; 0xFFFFFFCC sets it to 12
    task automatic test_dropped_writes();
        settle();
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd0);
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd1);
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd37);
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'd63);
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'h0000_0040);
        apb_transfer(APB_WRITE, SPARE_ADDR, 32'd5);
        apb_transfer(APB_READ, RADIX_ADDR, '0);
        apb_transfer(APB_WRITE, RADIX_ADDR, 32'hFFFF_FFCC);
        apb_transfer(APB_READ, RADIX_ADDR, '0);
        send_number(31'd143, 32'h4000_0000, 0);
        send_number(31'd11, '0, 0);
        send_number(31'h1234_5678, 32'h0F0F_0F0F, 2);
    endtask

    task automatic test_random_numbers();
        bit quiet_tx;
        for (int phase = 0; phase < 10; phase++) begin
            settle();
            if (phase == 0) apb_transfer(APB_WRITE, RADIX_ADDR, 32'd2);
            else if (phase == 1) apb_transfer(APB_WRITE, RADIX_ADDR, 32'd36);
            else apb_transfer(APB_WRITE, RADIX_ADDR, $urandom_range(2, 36));
            if ($urandom_range(0, 3) == 0) begin
                apb_transfer(APB_WRITE, RADIX_ADDR, $urandom_range(37, 63));
            end
            quiet_tx = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 28; k++) begin
                send_number(random_whole(), random_fraction(), quiet_tx ? 0 : random_gap());
            end
        end
    endtask

    // receiver goes quiet while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        settle();
        apb_transfer(APB_WRITE, RADIX_ADDR, $urandom_range(2, 36));
        @(posedge aclk);
        hold_request = 1'b1;
        for (int k = 0; k < 14; k++) begin
            send_number(random_whole(), random_fraction(), 0);
        end
    endtask

    initial begin : rx_side
        int stall_left;
        int mode_left;
        int r;
        bit choppy;
        stall_left = 0;
        mode_left = 150;
        choppy = 1'b1;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                choppy = !choppy;
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (choppy) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) stall_left = $urandom_range(1, 3);
                    else if (r < 22) stall_left = $urandom_range(15, 80);
                end
            end
        end
    end

    always @(posedge aclk) begin : char_check
        out_char_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_chars.size() == 0) begin
                flag_mismatch("character with nothing pending", -1, m_character);
            end else begin
                want = expected_chars.pop_front();
                if (m_character !== want.code) begin
                    flag_mismatch("character", want.code, m_character);
                end
                if (m_final_char !== want.last) begin
                    flag_mismatch("final_char", want.last, m_final_char);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_whole_value = '0;
        s_fraction_value = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_base_two();
        test_base_thirty_six();
        test_dropped_writes();
        test_random_numbers();
        test_output_backpressure();
        settle();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
